// File: src/uer_pkg.sv
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by ultrasonic_echo_ranger, ranger_checker and tb

package uer_pkg;

	// measurement phases
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_WAIT_LOW  = 3'd1,
		PH_TRIG      = 3'd2,
		PH_WAIT_RISE = 3'd3,
		PH_MEASURE   = 3'd4
	} phase_t;

	// configuration register indexes
	localparam logic [1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [1:0] REG_TRIGGER   = 2'd1;
	localparam logic [1:0] REG_HALFSPEED = 2'd2;

	// register widths and reset values
	localparam int TIMEOUT_W = 20;
	localparam int TRIGGER_W = 8;
	localparam int SPEED_W   = 18;
	localparam int CFG_W     = 20;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd50000;
	localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 8'd10;
	localparam logic [SPEED_W-1:0]   SPEED_RST   = 18'd112394;

	// distance output
	localparam int                  DIST_W   = 22;
	localparam logic [DIST_W-1:0]   DIST_MAX = 22'h3FFFFF;
	localparam int                  FRAC_W   = 16;

	// stream word widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 32;

endpackage

// File: src/ultrasonic_echo_ranger.sv
// ultrasonic_echo_ranger: tick-driven ultrasonic ranging sequencer
// depends on uer_pkg (phase type, register indexes, widths)
//
//  channel  | dir | payload (low bit first)
//  s_*      | in  | start_req, echo, zero pad to 8 bits
//  m_*      | out | trigger, busy_res, done_res, timed_out, distance_centi_cm, pad
//  cfg_*    | in  | timeout_ticks, trigger_ticks, half_speed_q16 by index
//
// one word in, one word out; a word enters every cycle while the result side is not
// stalled, and its result leaves through the input register, then the result register
// distance is the pulse count times the speed register, rounded and saturated, in the result cycle
// a stalled result register holds the input stage; the input stage still
// takes a word whenever it is empty or moving on
// reset clears phase, counters, valids and loads register defaults

module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int TICK_COUNT_BITS = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] start_req, [1] echo
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [0] trigger, [1] busy_res, [2] done_res,
	                                         // [3] timed_out, [25:4] distance_centi_cm
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	localparam int W     = TICK_COUNT_BITS;
	localparam int CMP_W = (W > TIMEOUT_W) ? W : TIMEOUT_W;
	localparam int ACC_W = W + SPEED_W;
	localparam int RND_W = ACC_W + 1;
	localparam int D_W   = RND_W - FRAC_W;
	localparam int DC_W  = (D_W > DIST_W) ? D_W : DIST_W;
	localparam logic [W-1:0]     CNT_MAX = {W{1'b1}};
	localparam logic [RND_W-1:0] HALF    = RND_W'(1) << (FRAC_W - 1);

	// configuration registers
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TRIGGER_W-1:0] trig_ticks_q;
	logic [SPEED_W-1:0]   speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RST;
			trig_ticks_q <= TRIGGER_RST;
			speed_q      <= SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TIMEOUT:   timeout_q    <= cfg_wdata[TIMEOUT_W-1:0];
				REG_TRIGGER:   trig_ticks_q <= cfg_wdata[TRIGGER_W-1:0];
				REG_HALFSPEED: speed_q      <= cfg_wdata[SPEED_W-1:0];
				default:       ;
			endcase
		end
	end

	// input register
	logic valid_s1, start_s1, echo_s1, advance;
	logic out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			echo_s1  <= s_tdata[1];
		end
	end

	// sequencer state
	phase_t               phase_q, phase_d;
	logic [W-1:0]         elapsed_q, elapsed_d, pulse_q, pulse_d;
	logic [TRIGGER_W-1:0] trig_left_q, trig_left_d;

	logic [W-1:0] elapsed_inc, pulse_inc;
	logic         elapsed_over, pulse_over;

	// saturating counts and timeout checks
	assign elapsed_inc  = (elapsed_q == CNT_MAX) ? CNT_MAX : elapsed_q + W'(1);
	assign pulse_inc    = (pulse_q == CNT_MAX) ? CNT_MAX : pulse_q + W'(1);
	assign elapsed_over = (CMP_W'(elapsed_inc) > CMP_W'(timeout_q)) || (elapsed_inc == CNT_MAX);
	assign pulse_over   = (CMP_W'(pulse_inc) > CMP_W'(timeout_q)) || (pulse_inc == CNT_MAX);

	// rounded and saturated distance from the pulse product
	logic [ACC_W-1:0]  pulse_prod;
	logic [RND_W-1:0]  rnd;
	logic [DC_W-1:0]   dist_full;
	logic [DIST_W-1:0] dist_sat;

	assign pulse_prod = ACC_W'(pulse_q) * ACC_W'(speed_q);
	assign rnd        = RND_W'(pulse_prod) + HALF;
	assign dist_full  = DC_W'(rnd[RND_W-1:FRAC_W]);
	assign dist_sat   = (dist_full > DC_W'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];

	// next state
	always_comb begin
		phase_d     = phase_q;
		elapsed_d   = elapsed_q;
		pulse_d     = pulse_q;
		trig_left_d = trig_left_q;
		case (phase_q)
			PH_WAIT_LOW: begin
				elapsed_d = elapsed_inc;
				if (!echo_s1) begin
					trig_left_d = (trig_ticks_q == '0) ? TRIGGER_W'(1) : trig_ticks_q;
					phase_d     = PH_TRIG;
				end
			end
			PH_TRIG: begin
				elapsed_d = elapsed_inc;
				if (trig_left_q <= TRIGGER_W'(1)) begin
					trig_left_d = '0;
					phase_d     = PH_WAIT_RISE;
				end else begin
					trig_left_d = trig_left_q - TRIGGER_W'(1);
				end
			end
			PH_WAIT_RISE: begin
				elapsed_d = elapsed_inc;
				if (echo_s1) begin
					pulse_d = '0;
					phase_d = PH_MEASURE;
				end else if (elapsed_over) begin
					phase_d = PH_IDLE;
				end
			end
			PH_MEASURE: begin
				elapsed_d = elapsed_inc;
				if (echo_s1) begin
					pulse_d = pulse_inc;
					if (pulse_over) phase_d = PH_IDLE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (start_s1) begin
					elapsed_d   = '0;
					pulse_d     = '0;
					trig_left_d = '0;
					phase_d     = PH_WAIT_LOW;
				end
			end
		endcase
	end

	// result fields
	logic              trig_o, done_o, tout_o;
	logic [DIST_W-1:0] dist_o;

	always_comb begin
		trig_o = 1'b0;
		done_o = 1'b0;
		tout_o = 1'b0;
		dist_o = '0;
		case (phase_q)
			PH_TRIG: trig_o = 1'b1;
			PH_WAIT_RISE: begin
				if (!echo_s1 && elapsed_over) begin
					done_o = 1'b1;
					tout_o = 1'b1;
				end
			end
			PH_MEASURE: begin
				if (echo_s1) begin
					done_o = pulse_over;
					tout_o = pulse_over;
				end else begin
					done_o = 1'b1;
					dist_o = dist_sat;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			pulse_q     <= '0;
			trig_left_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			elapsed_q   <= elapsed_d;
			pulse_q     <= pulse_d;
			trig_left_q <= trig_left_d;
		end
	end

	// result register
	logic [OUT_DATA_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {6'b0, dist_o, tout_o, done_o, phase_d != PH_IDLE, trig_o};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	// a finished measurement is never reported busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> !m_tdata[1])
		else $error("done word still busy");

	// a timeout only comes with done and zero distance
	a_tout_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> (m_tdata[2] && m_tdata[25:4] == '0))
		else $error("timeout word malformed");

	// trigger drives only during a measurement
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[1])
		else $error("trigger outside measurement");

	// the pulse count starts from zero when a pulse starts
	a_pulse_clear: assert property (@(posedge clk) disable iff (!arst_n)
		($past(advance) && phase_q == PH_MEASURE && $past(phase_q) == PH_WAIT_RISE)
		|-> (pulse_q == '0))
		else $error("pulse count not cleared");
`endif

endmodule

// File: tb/sv/ranger_checker.sv
// ranger_checker: watches the tick, result and config ports of the echo ranger,
// predicts every result word from its own copy of the ranging state and compares
// depends on uer_pkg (phase type, register indexes, widths, reset values)

module ranger_checker
	import uer_pkg::*;
#(
	parameter int TICK_COUNT_BITS = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] start_req, [1] echo
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // [0] trigger, [1] busy_res, [2] done_res,
	                                         // [3] timed_out, [25:4] distance_centi_cm
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	output int                    backlog,
	output int                    fail_count
);

	localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

	// result word, trigger in the lowest bit
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              timed_out;
		logic              done;
		logic              busy;
		logic              trigger;
	} tick_word_t;

	// mirrored registers
	logic [TIMEOUT_W-1:0]       timeout_lim;
	logic [TRIGGER_W-1:0]       trig_len;
	logic [SPEED_W-1:0]         half_speed;

	// predicted ranging state
	phase_t                     phase;
	logic [TICK_COUNT_BITS-1:0] elapsed;
	logic [TICK_COUNT_BITS-1:0] pulse_len;
	logic [TRIGGER_W-1:0]       trig_left;

	tick_word_t ranging_q[$];

	function automatic logic [TICK_COUNT_BITS-1:0] sat_count(
		input logic [TICK_COUNT_BITS-1:0] v);
		return (v == TICK_MAX) ? v : v + TICK_COUNT_BITS'(1);
	endfunction

	// a saturated counter counts as over the limit
	function automatic logic past_limit(input logic [TICK_COUNT_BITS-1:0] v);
		return (32'(v) > 32'(timeout_lim)) || (v == TICK_MAX);
	endfunction

	// advance the ranging state by one tick and return the word it produces
	function automatic tick_word_t ranger_tick(input logic start, input logic echo);
		tick_word_t  r;
		logic [63:0] prod;
		r = '0;
		case (phase)
		PH_WAIT_LOW: begin
			elapsed = sat_count(elapsed);
			if (!echo) begin
				// a zero trigger length still gives one trigger tick
				trig_left = (trig_len == '0) ? TRIGGER_W'(1) : trig_len;
				phase = PH_TRIG;
			end
		end
		PH_TRIG: begin
			r.trigger = 1'b1;
			elapsed = sat_count(elapsed);
			if (trig_left <= TRIGGER_W'(1)) begin
				trig_left = '0;
				phase = PH_WAIT_RISE;
			end else
				trig_left = trig_left - TRIGGER_W'(1);
		end
		PH_WAIT_RISE: begin
			elapsed = sat_count(elapsed);
			if (echo) begin
				pulse_len = '0;
				phase = PH_MEASURE;
			end else if (past_limit(elapsed)) begin
				r.done = 1'b1;
				r.timed_out = 1'b1;
				phase = PH_IDLE;
			end
		end
		PH_MEASURE: begin
			elapsed = sat_count(elapsed);
			if (echo) begin
				pulse_len = sat_count(pulse_len);
				if (past_limit(pulse_len)) begin
					r.done = 1'b1;
					r.timed_out = 1'b1;
					phase = PH_IDLE;
				end
			end else begin
				// Q16 product, rounded half up, clipped to the distance range
				r.done = 1'b1;
				prod = (64'(pulse_len) * 64'(half_speed) + 64'h8000) >> FRAC_W;
				r.distance = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
				phase = PH_IDLE;
			end
		end
		default: begin
			phase = PH_IDLE;
			if (start) begin
				elapsed = '0;
				pulse_len = '0;
				trig_left = '0;
				phase = PH_WAIT_LOW;
			end
		end
		endcase
		r.busy = (phase != PH_IDLE);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DIST_W-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// compare results, predict accepted ticks, follow register writes
	always @(posedge clk or negedge arst_n) begin : watch
		tick_word_t seen, want;
		if (!arst_n) begin
			timeout_lim = TIMEOUT_RST;
			trig_len = TRIGGER_RST;
			half_speed = SPEED_RST;
			phase = PH_IDLE;
			elapsed = '0;
			pulse_len = '0;
			trig_left = '0;
			ranging_q.delete();
			fail_count = 0;
			backlog = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = tick_word_t'(m_tdata[DIST_W+3:0]);
				if (ranging_q.size() == 0) begin
					$error("result word with no tick waiting for it: %h", m_tdata);
					fail_count++;
				end else begin
					want = ranging_q.pop_front();
					check_field("trigger", DIST_W'(want.trigger), DIST_W'(seen.trigger));
					check_field("busy_res", DIST_W'(want.busy), DIST_W'(seen.busy));
					check_field("done_res", DIST_W'(want.done), DIST_W'(seen.done));
					check_field("timed_out", DIST_W'(want.timed_out),
						DIST_W'(seen.timed_out));
					check_field("distance_centi_cm", want.distance, seen.distance);
				end
			end
			if (s_tvalid && s_tready)
				ranging_q.push_back(ranger_tick(s_tdata[0], s_tdata[1]));
			if (cfg_we) begin
				case (cfg_addr)
				REG_TIMEOUT:   timeout_lim = cfg_wdata[TIMEOUT_W-1:0];
				REG_TRIGGER:   trig_len = cfg_wdata[TRIGGER_W-1:0];
				REG_HALFSPEED: half_speed = cfg_wdata[SPEED_W-1:0];
				default: ;
				endcase
			end
			backlog = ranging_q.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// tb: drives ping sequences, noise ticks and register settings into the echo ranger,
// with a stalling result receiver; depends on uer_pkg, ranger_checker and the block

module tb;
	import uer_pkg::*;

	localparam int TICK_BITS   = 21;
	localparam int TICK_TARGET = 1350;
	localparam int IDLE_LIMIT  = 2000;
	localparam int LONG_HOLD   = 60;
	localparam int HOLD_AT     = 150;

	// index past the last register, writes there must be dropped
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_TOP = '1;
	localparam logic [TRIGGER_W-1:0] TRIGGER_TOP = '1;
	localparam logic [SPEED_W-1:0]   SPEED_TOP   = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // [0] start_req, [1] echo
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [0] trigger, [1] busy_res, [2] done_res,
	                                  // [3] timed_out, [25:4] distance_centi_cm
	logic                  cfg_we;
	logic [1:0]            cfg_addr;
	logic [CFG_W-1:0]      cfg_wdata;

	int                    backlog;
	int                    fail_count;
	int                    ticks_sent;
	bit                    steady;        // both sides skip their random gaps while set
	logic [TRIGGER_W-1:0]  trig_now;

	ultrasonic_echo_ranger #(.TICK_COUNT_BITS(TICK_BITS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	ranger_checker #(.TICK_COUNT_BITS(TICK_BITS)) ranger_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.backlog    (backlog),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result receiver: random hold-off per word, one long hold to back the block up
	initial begin : result_sink
		int hold;
		int words;
		words = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 4);
			if (words == HOLD_AT)
				hold = LONG_HOLD;
			if (hold > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			words++;
		end
	end

	// stop when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// one tick word, after a random gap
	task automatic send_tick(input logic start, input logic lvl);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W-2){1'b0}}, lvl, start};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_drained();
		@(negedge clk) s_tvalid <= 1'b0;
		while (backlog != 0) @(negedge clk);
	endtask

	task automatic load_config(input logic [TIMEOUT_W-1:0] to,
		input logic [TRIGGER_W-1:0] tr, input logic [SPEED_W-1:0] sp);
		wait_drained();
		write_reg(REG_TIMEOUT, to);
		// bits above a register's width are junk the block must drop
		write_reg(REG_TRIGGER, CFG_W'({$urandom(), tr}));
		write_reg(REG_HALFSPEED, CFG_W'({$urandom(), sp}));
		write_reg(REG_UNUSED, CFG_W'($urandom()));
		trig_now = tr;
	endtask

	// one full ping from idle: echo still high for a while, trigger, wait, echo pulse
	// of pulse ticks; extra start requests land only while the block is busy
	task automatic measure_once(input int settle, input int rise, input int pulse);
		int trig_eff;
		trig_eff = (trig_now == '0) ? 1 : int'(trig_now);
		send_tick(1'b1, 1'($urandom));
		repeat (settle) send_tick(1'($urandom), 1'b1);
		send_tick(1'($urandom), 1'b0);
		repeat (trig_eff) send_tick(1'($urandom), 1'($urandom));
		repeat (rise) send_tick(1'b0, 1'b0);
		repeat (pulse + 1) send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
	endtask

	// random ticks, then a toggling echo that walks any started ping to its end
	task automatic noise_burst(input int n);
		logic lvl;
		lvl = 1'b0;
		repeat (n) send_tick(1'($urandom), 1'($urandom));
		repeat ((trig_now == '0 ? 1 : int'(trig_now)) + 8) begin
			send_tick(1'b0, lvl);
			lvl = ~lvl;
		end
	endtask

	initial begin : stimulus
		int                   to;
		int                   rise;
		int                   pulse;
		logic [TRIGGER_W-1:0] tr;
		logic [SPEED_W-1:0]   sp;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		steady = 1'b0;
		ticks_sent = 0;
		trig_now = TRIGGER_RST;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset settings: a short echo and an echo with no length
		measure_once(1, 2, 3);
		measure_once(0, 0, 0);

		// all-zero settings: zero timeout on both waits, zero trigger length, zero speed
		load_config('0, '0, '0);
		measure_once(0, 0, 2);
		measure_once(1, 1, 0);

		// widest timeout, top speed, shortest trigger
		load_config(TIMEOUT_TOP, 8'd1, SPEED_TOP);
		measure_once(0, 3, 5);
		noise_burst(6);

		// longest trigger
		load_config(TIMEOUT_TOP, TRIGGER_TOP, SPEED_TOP);
		measure_once(2, 4, 30);

		// random settings, mostly short timeouts so both timeouts and echoes occur
		while (ticks_sent < TICK_TARGET) begin
			steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
			0:       to = $urandom_range(0, 6);
			1, 2:    to = $urandom_range(7, 40);
			3:       to = $urandom_range(41, 300);
			default: to = int'(TIMEOUT_TOP);
			endcase
			tr = ($urandom_range(0, 5) == 0) ? '0 : TRIGGER_W'($urandom_range(1, 12));
			sp = SPEED_W'($urandom_range(0, SPEED_TOP));
			load_config(TIMEOUT_W'(to), tr, sp);
			repeat ($urandom_range(3, 8)) begin
				rise = $urandom_range(0, (to < 50) ? to + 4 : 50);
				pulse = $urandom_range(0, (to < 50) ? to + 2 : 50);
				if (to == int'(TIMEOUT_TOP) && $urandom_range(0, 7) == 0)
					pulse = $urandom_range(200, 600);
				if ($urandom_range(0, 5) == 0)
					noise_burst($urandom_range(2, 10));
				else
					measure_once($urandom_range(0, 3), rise, pulse);
			end
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
